>>> src/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and byte classes for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int LINE_BITS_DEF   = 16;
  localparam int COLUMN_BITS_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;

  localparam int KIND_W   = 3;
  localparam int LINE_W   = 16;
  localparam int COLUMN_W = 16;
  localparam int OFFSET_W = 32;

  localparam logic [KIND_W-1:0] KIND_COMMENT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SYMBOL  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TEXT    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_LCOMMENT,
    MODE_BOPEN,
    MODE_BCOMMENT,
    MODE_SQUOTE,
    MODE_DQUOTE,
    MODE_ERROR
  } lex_mode_t;

  typedef struct packed {
    lex_mode_t mode;
    logic      backslash_odd;
    logic      star_seen;
  } lex_ctl_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [LINE_W-1:0]   line;
    logic [COLUMN_W-1:0] column;
    logic [OFFSET_W-1:0] offset;
    logic                run_end;
  } result_t;

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    logic hit;
    case (c)
      8'h21, 8'h22, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C,
      8'h2D, 8'h2E, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
      8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h5F, 8'h7B, 8'h7C, 8'h7D, 8'h7E: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

>>> src/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming tokenizer: reports the start of each token in a byte stream.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle. Each byte gives zero, one or two result
// beats, which wait in a four-entry result queue; the input stalls while the
// queue has fewer than two free entries, so the sustained rate is one byte per
// cycle while results average at most one per byte, and is set by the one
// result beat per cycle of the output port otherwise. Results are registered
// in the queue before they leave. Bytes are classified one step late (one
// byte of lookahead); is_last flushes the held byte. After an invalid byte is
// reported, all input is taken and dropped until reset.
module source_text_tokenizer #(
  parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF,
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   source_byte,
  input  logic                         is_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [stt_pkg::KIND_W-1:0]   event_kind,
  output logic [stt_pkg::LINE_W-1:0]   token_line,
  output logic [stt_pkg::COLUMN_W-1:0] token_column,
  output logic [stt_pkg::OFFSET_W-1:0] token_offset,
  output logic                         run_end
);
  import stt_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  lex_ctl_t               ctl;
  logic [7:0]             held_byte;
  logic                   held_valid;
  logic [LINE_BITS-1:0]   line_count;
  logic [COLUMN_BITS-1:0] column_count;
  logic [OFFSET_BITS-1:0] byte_offset;

  lex_ctl_t               ctl_a, ctl_s1, ctl_b;
  logic [LINE_BITS-1:0]   line_a, line_s1, line_b;
  logic [COLUMN_BITS-1:0] column_a, column_s1, column_b;
  logic [OFFSET_BITS-1:0] offset_a, offset_s1, offset_b;
  logic                   emit_a, emit_b;
  logic [KIND_W-1:0]      kind_a, kind_b;

  logic                   in_acc, step, second, r1, r2, pop;
  result_t                res_a, res_b, push_first;
  logic [1:0]             push_n;

  result_t                queue [QDEPTH];
  logic [QPTR_W-1:0]      wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]      count;

  stt_classify #(
    .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS), .OFFSET_BITS(OFFSET_BITS)
  ) u_held (
    .ctl_in(ctl), .line_in(line_count), .column_in(column_count),
    .offset_in(byte_offset), .c(held_byte), .la(source_byte), .la_ok(1'b1),
    .ctl_out(ctl_a), .line_out(line_a), .column_out(column_a),
    .offset_out(offset_a), .emit(emit_a), .kind(kind_a)
  );

  assign ctl_s1    = held_valid ? ctl_a    : ctl;
  assign line_s1   = held_valid ? line_a   : line_count;
  assign column_s1 = held_valid ? column_a : column_count;
  assign offset_s1 = held_valid ? offset_a : byte_offset;

  stt_classify #(
    .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS), .OFFSET_BITS(OFFSET_BITS)
  ) u_last (
    .ctl_in(ctl_s1), .line_in(line_s1), .column_in(column_s1),
    .offset_in(offset_s1), .c(source_byte), .la(8'h00), .la_ok(1'b0),
    .ctl_out(ctl_b), .line_out(line_b), .column_out(column_b),
    .offset_out(offset_b), .emit(emit_b), .kind(kind_b)
  );

  assign in_acc = in_valid && !in_stall;
  assign step   = in_acc && ctl.mode != MODE_ERROR;
  assign second = is_last && ctl_s1.mode != MODE_ERROR;
  assign r1     = step && held_valid && emit_a;
  assign r2     = step && second && emit_b;
  assign push_n = {1'b0, r1} + {1'b0, r2};

  assign res_a = '{kind: kind_a, line: LINE_W'(line_count),
                   column: COLUMN_W'(column_count), offset: OFFSET_W'(byte_offset),
                   run_end: !r2};
  assign res_b = '{kind: kind_b, line: LINE_W'(line_s1),
                   column: COLUMN_W'(column_s1), offset: OFFSET_W'(offset_s1),
                   run_end: 1'b1};
  assign push_first = r1 ? res_a : res_b;

  assign in_stall  = count > QCNT_W'(QDEPTH - 2);
  assign out_valid = count != '0;
  assign pop       = out_valid && !out_stall;

  assign event_kind   = queue[rd_ptr].kind;
  assign token_line   = queue[rd_ptr].line;
  assign token_column = queue[rd_ptr].column;
  assign token_offset = queue[rd_ptr].offset;
  assign run_end      = queue[rd_ptr].run_end;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) queue[wr_ptr] <= push_first;
    if (push_n == 2'd2) queue[wr_ptr + QPTR_W'(1)] <= res_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push_n) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl          <= '{mode: MODE_IDLE, backslash_odd: 1'b0, star_seen: 1'b0};
      held_byte    <= '0;
      held_valid   <= 1'b0;
      line_count   <= LINE_BITS'(1);
      column_count <= COLUMN_BITS'(1);
      byte_offset  <= '0;
    end else if (step) begin
      if (second) begin
        ctl          <= ctl_b;
        line_count   <= line_b;
        column_count <= column_b;
        byte_offset  <= offset_b;
      end else begin
        ctl          <= ctl_s1;
        line_count   <= line_s1;
        column_count <= column_s1;
        byte_offset  <= offset_s1;
      end
      if (ctl_s1.mode == MODE_ERROR) begin
        held_valid <= 1'b0;
      end else if (is_last) begin
        held_valid <= 1'b0;
        held_byte  <= '0;
      end else begin
        held_byte  <= source_byte;
        held_valid <= 1'b1;
      end
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH)) else $error("result queue overfilled");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    ctl.mode == MODE_ERROR |=> ctl.mode == MODE_ERROR)
    else $error("error mode left without reset");

  a_error_no_held: assert property (@(posedge clk) disable iff (rst)
    ctl.mode == MODE_ERROR |-> !held_valid)
    else $error("lookahead byte held in error mode");

  a_pair_queued: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_end |-> count >= QCNT_W'(2))
    else $error("first of a result pair without its partner");

  a_no_push_in_error: assert property (@(posedge clk) disable iff (rst)
    ctl.mode == MODE_ERROR |-> push_n == 2'd0)
    else $error("result pushed in error mode");

endmodule

>>> src/stt_classify.sv
// ----------------------------------------------------------------------------
// stt_classify
// Classifies one byte against the lexer state with optional lookahead and
// gives the next state, the advanced position counters and any token event.
// ----------------------------------------------------------------------------
module stt_classify #(
  parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF,
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
  input  stt_pkg::lex_ctl_t          ctl_in,
  input  logic [LINE_BITS-1:0]       line_in,
  input  logic [COLUMN_BITS-1:0]     column_in,
  input  logic [OFFSET_BITS-1:0]     offset_in,
  input  logic [7:0]                 c,
  input  logic [7:0]                 la,
  input  logic                       la_ok,
  output stt_pkg::lex_ctl_t          ctl_out,
  output logic [LINE_BITS-1:0]       line_out,
  output logic [COLUMN_BITS-1:0]     column_out,
  output logic [OFFSET_BITS-1:0]     offset_out,
  output logic                       emit,
  output logic [stt_pkg::KIND_W-1:0] kind
);
  import stt_pkg::*;

  logic      idle_here;
  logic      crlf;
  logic      quote_hit;
  logic      counting;
  logic [7:0] quote;

  assign crlf  = c == CH_CR && la_ok && la == CH_LF;
  assign quote = (ctl_in.mode == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
  assign quote_hit = c == quote && !ctl_in.backslash_odd;

  always_comb begin
    ctl_out   = ctl_in;
    idle_here = 1'b0;
    emit      = 1'b0;
    kind      = KIND_ERROR;
    case (ctl_in.mode)
      MODE_IDLE: begin
        idle_here = 1'b1;
      end
      MODE_IDENT: begin
        if (!is_ident(c)) begin
          ctl_out.mode = MODE_IDLE;
          idle_here    = 1'b1;
        end
      end
      MODE_LCOMMENT: begin
        if (c == CH_LF) begin
          if (ctl_in.backslash_odd) ctl_out.backslash_odd = 1'b0;
          else ctl_out.mode = MODE_IDLE;
        end else if (!crlf) begin
          ctl_out.backslash_odd = (c == CH_BSLASH) ? !ctl_in.backslash_odd : 1'b0;
        end
      end
      MODE_BOPEN: begin
        ctl_out.mode      = MODE_BCOMMENT;
        ctl_out.star_seen = 1'b0;
      end
      MODE_BCOMMENT: begin
        if (c == CH_SLASH && ctl_in.star_seen) begin
          ctl_out.mode      = MODE_IDLE;
          ctl_out.star_seen = 1'b0;
        end else begin
          ctl_out.star_seen = c == CH_STAR;
        end
      end
      MODE_SQUOTE, MODE_DQUOTE: begin
        if (quote_hit) ctl_out.mode = MODE_IDLE;
        else ctl_out.backslash_odd = (c == CH_BSLASH) ? !ctl_in.backslash_odd : 1'b0;
      end
      default: begin
      end
    endcase

    if (idle_here) begin
      if (c == CH_SLASH && la_ok && (la == CH_SLASH || la == CH_STAR)) begin
        emit                  = 1'b1;
        kind                  = KIND_COMMENT;
        ctl_out.mode          = (la == CH_SLASH) ? MODE_LCOMMENT : MODE_BOPEN;
        ctl_out.backslash_odd = 1'b0;
        ctl_out.star_seen     = 1'b0;
      end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
        emit                  = 1'b1;
        kind                  = KIND_TEXT;
        ctl_out.mode          = (c == CH_SQUOTE) ? MODE_SQUOTE : MODE_DQUOTE;
        ctl_out.backslash_odd = 1'b0;
      end else if (is_ident(c)) begin
        emit         = 1'b1;
        kind         = KIND_IDENT;
        ctl_out.mode = MODE_IDENT;
      end else if (is_symbol(c)) begin
        emit = 1'b1;
        kind = KIND_SYMBOL;
      end else if (c == CH_SPACE || c == CH_LF || crlf) begin
        emit = 1'b0;
      end else begin
        emit         = 1'b1;
        kind         = KIND_ERROR;
        ctl_out.mode = MODE_ERROR;
      end
    end
  end

  assign counting = ctl_in.mode != MODE_ERROR && ctl_out.mode != MODE_ERROR;

  always_comb begin
    line_out   = line_in;
    column_out = column_in;
    offset_out = offset_in;
    if (counting) begin
      if (c == CH_LF) begin
        line_out   = (&line_in) ? line_in : line_in + LINE_BITS'(1);
        column_out = COLUMN_BITS'(1);
      end else begin
        column_out = (&column_in) ? column_in : column_in + COLUMN_BITS'(1);
      end
      offset_out = (&offset_in) ? offset_in : offset_in + OFFSET_BITS'(1);
    end
  end

endmodule
